### hw/rtl/quadratic_bezier_path_flattener_macros.svh
// assertion macros of the flattener checker
`ifndef QUADRATIC_BEZIER_PATH_FLATTENER_MACROS_SVH
`define QUADRATIC_BEZIER_PATH_FLATTENER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define QBF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define QBF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/qbf_pkg.sv
// shared types and constants of the quadratic bezier path flattener
package qbf_pkg;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_MOVE   = 2'd0;
  localparam opcode_t OP_LINE   = 2'd1;
  localparam opcode_t OP_SPLINE = 2'd2;
  localparam opcode_t OP_RSVD   = 2'd3;

  // 25 * 65536: scale of parts^2 against 144 * |second difference|
  localparam int PART_SCALE = 1638400;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_END      = 9'b000000010,
    S_PREP     = 9'b000000100,
    S_SUM      = 9'b000001000,
    S_COUNT    = 9'b000010000,
    S_DEN      = 9'b000100000,
    S_DIV_GO   = 9'b001000000,
    S_DIV_WAIT = 9'b010000000,
    S_PTS      = 9'b100000000
  } state_t;

  // divider job: msb picks the lane (x or y), lsb first or second difference
  typedef enum logic [1:0] {
    DIV_DX = 2'b00,
    DIV_SX = 2'b01,
    DIV_DY = 2'b10,
    DIV_SY = 2'b11
  } div_sel_t;

endpackage

### hw/rtl/qbf_ifs.sv
// valid/ready channel interfaces for path elements and polyline points
interface qbf_in_if #(
  parameter int CW = 32
);
  logic                 valid;
  logic                 ready;
  qbf_pkg::opcode_t     opcode;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic signed [CW-1:0] ctrl_x;
  logic signed [CW-1:0] ctrl_y;

  modport source (output valid, output opcode, output end_x, output end_y,
                  output ctrl_x, output ctrl_y, input ready);
  modport sink   (input valid, input opcode, input end_x, input end_y,
                  input ctrl_x, input ctrl_y, output ready);
endinterface

interface qbf_out_if #(
  parameter int CW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic                 new_subpath;
  logic                 last_of_run;

  modport source (output valid, output point_x, output point_y,
                  output new_subpath, output last_of_run, input ready);
  modport sink   (input valid, input point_x, input point_y,
                  input new_subpath, input last_of_run, output ready);
endinterface

### hw/rtl/qbf_div.sv
// bit-serial restoring divider, floor quotient of a signed value by a positive divisor
module qbf_div #(
  parameter int WN  = 42,
  parameter int WDN = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [WN-1:0]  dividend,
  input  logic        [WDN-1:0] divisor,
  output logic                  done,
  output logic signed [WN-1:0]  quot,
  output logic        [WDN-1:0] rem
);

  localparam int CNTW = $clog2(WN + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [WN-1:0]   acc_r;
  logic [WDN-1:0]  rem_r;
  logic [WDN-1:0]  den_r;
  logic            neg_r;

  logic [WDN:0]    rem_sh;
  logic [WDN:0]    diff;
  logic            fits;
  logic            rem_nz;

  assign rem_sh = {rem_r, acc_r[WN-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = !diff[WDN];
  assign rem_nz = |rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(WN);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[WN-1];
      acc_r <= dividend[WN-1] ? -dividend : dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[WDN-1:0] : rem_sh[WDN-1:0];
      acc_r <= {acc_r[WN-2:0], fits};
    end
  end

  // magnitude result turned into floor division for negative dividends
  always_comb begin
    if (neg_r && rem_nz) begin
      quot = ~acc_r;
      rem  = den_r - rem_r;
    end else if (neg_r) begin
      quot = -acc_r;
      rem  = rem_r;
    end else begin
      quot = acc_r;
      rem  = rem_r;
    end
  end

  assign done = done_r;

endmodule

### hw/rtl/quadratic_bezier_path_flattener.sv
// Quadratic bezier path flattener: moves, lines and splines into polyline points.
// Move or line: S_IDLE takes it, S_END offers its end point and returns to S_IDLE.
// Spline: S_PREP, S_SUM, the part count search in S_COUNT, S_DEN, four divisions through
// S_DIV_GO and S_DIV_WAIT, then the points in S_PTS and the end point in S_END.
// S_PTS and S_END stall on the output. The serial divider gives one quotient bit per cycle.
// Synchronous active-low reset: idle, output empty, kept point at (0, 0).
module quadratic_bezier_path_flattener #(
  parameter int MAX_PARTS   = 63,
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  qbf_in_if.sink    in_if,
  qbf_out_if.source out_if
);

  import qbf_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int NW    = $clog2(MAX_PARTS + 1);
  localparam int DEN_W = 2 * NW + 1;
  localparam int WA    = CW + 2;
  localparam int WB    = CW + NW + 2;
  localparam int WP    = CW + NW + 3;
  localparam int WQ    = CW + NW + 4;
  localparam int WC    = (CW + 11 > 2 * NW + 22) ? CW + 11 : 2 * NW + 22;

  state_t state_r, state_nxt;

  opcode_t              op_r;
  logic signed [CW-1:0] e_r [2];
  logic signed [CW-1:0] c_r [2];
  logic signed [CW-1:0] p_r [2];
  logic signed [WA-1:0] a_r [2];
  logic signed [CW:0]   d_r [2];
  logic signed [WB-1:0] b_r [2];

  logic [WC-1:0]       rhs_r, lhs_r, step_r;
  logic [NW-1:0]       n_r, i_r;
  logic [2*NW-1:0]     nsq_r;
  div_sel_t            div_sel_r;

  // value, first difference and second difference as quotient/remainder pairs
  logic signed [WQ-1:0] vq_r [2];
  logic signed [WQ-1:0] fq_r [2];
  logic signed [WQ-1:0] sq_r [2];
  logic [DEN_W-1:0]     vr_r [2];
  logic [DEN_W-1:0]     fr_r [2];
  logic [DEN_W-1:0]     sr_r [2];

  logic                 out_valid_r;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic                 out_ns_r, out_last_r;

  logic                 in_fire, out_free, out_load, count_go, last_pt;
  logic [DEN_W-1:0]     den;
  logic [WA-1:0]        a_abs [2];
  logic [WA:0]          d_sum;
  logic [WC-1:0]        rhs_nxt;
  logic signed [WP-1:0] b_prod [2];
  logic [DEN_W:0]       vr_sum [2];
  logic [DEN_W:0]       fr_sum [2];
  logic                 v_wrap [2];
  logic                 f_wrap [2];
  logic signed [WQ-1:0] vq_upd [2];
  logic signed [WQ-1:0] fq_upd [2];
  logic [DEN_W-1:0]     vr_upd [2];
  logic [DEN_W-1:0]     fr_upd [2];
  logic                 lane;
  logic signed [WQ-1:0] dvd;
  logic                 div_start, div_done;
  logic signed [WQ-1:0] div_q;
  logic [DEN_W-1:0]     div_r;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign out_load    = out_free && (state_r == S_PTS || state_r == S_END);
  assign den         = {nsq_r, 1'b0};
  assign count_go    = (n_r < NW'(MAX_PARTS)) && (lhs_r <= rhs_r);
  assign last_pt     = (i_r == n_r - NW'(1));
  assign div_start   = (state_r == S_DIV_GO);
  assign lane        = div_sel_r[1];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      a_abs[k]  = a_r[k][WA-1] ? WA'(-a_r[k]) : WA'(a_r[k]);
      b_prod[k] = WP'($signed({1'b0, n_r, 1'b0})) * WP'(d_r[k]);
      vr_sum[k] = {1'b0, vr_r[k]} + {1'b0, fr_r[k]};
      fr_sum[k] = {1'b0, fr_r[k]} + {1'b0, sr_r[k]};
      v_wrap[k] = (vr_sum[k] >= {1'b0, den});
      f_wrap[k] = (fr_sum[k] >= {1'b0, den});
      vr_upd[k] = v_wrap[k] ? DEN_W'(vr_sum[k] - {1'b0, den}) : vr_sum[k][DEN_W-1:0];
      fr_upd[k] = f_wrap[k] ? DEN_W'(fr_sum[k] - {1'b0, den}) : fr_sum[k][DEN_W-1:0];
      vq_upd[k] = vq_r[k] + fq_r[k] + $signed({{(WQ-1){1'b0}}, v_wrap[k]});
      fq_upd[k] = fq_r[k] + sq_r[k] + $signed({{(WQ-1){1'b0}}, f_wrap[k]});
    end
  end

  // 144 * D as shift-add
  assign d_sum   = {1'b0, a_abs[0]} + {1'b0, a_abs[1]};
  assign rhs_nxt = (WC'(d_sum) << 7) + (WC'(d_sum) << 4);

  // first difference 2a + 2b, second difference 4a, both scaled by 2
  always_comb begin
    case (div_sel_r)
      DIV_DX, DIV_DY: dvd = (WQ'(a_r[lane]) <<< 1) + (WQ'(b_r[lane]) <<< 1);
      DIV_SX, DIV_SY: dvd = WQ'(a_r[lane]) <<< 2;
      default:        dvd = '0;
    endcase
  end

  qbf_div #(
    .WN  (WQ),
    .WDN (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (den),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_if.opcode)
            OP_MOVE, OP_LINE: state_nxt = S_END;
            OP_SPLINE:        state_nxt = S_PREP;
            default:          state_nxt = S_IDLE;
          endcase
        end
      end
      S_END:      if (out_free) state_nxt = S_IDLE;
      S_PREP:     state_nxt = S_SUM;
      S_SUM:      state_nxt = S_COUNT;
      S_COUNT:    if (!count_go) state_nxt = S_DEN;
      S_DEN:      state_nxt = S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) state_nxt = (div_sel_r == DIV_SY) ? S_PTS : S_DIV_GO;
      end
      S_PTS:      if (out_free && last_pt) state_nxt = S_END;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      p_r[0]      <= '0;
      p_r[1]      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_END && out_free) begin
        p_r[0] <= e_r[0];
        p_r[1] <= e_r[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_r   <= in_if.opcode;
          e_r[0] <= in_if.end_x;
          e_r[1] <= in_if.end_y;
          c_r[0] <= in_if.ctrl_x;
          c_r[1] <= in_if.ctrl_y;
        end
      end
      S_PREP: begin
        for (int k = 0; k < 2; k++) begin
          a_r[k] <= WA'(e_r[k]) - (WA'(c_r[k]) <<< 1) + WA'(p_r[k]);
          d_r[k] <= (CW+1)'(c_r[k]) - (CW+1)'(p_r[k]);
        end
      end
      S_SUM: begin
        rhs_r  <= rhs_nxt;
        n_r    <= '0;
        lhs_r  <= WC'(PART_SCALE);
        step_r <= WC'(3 * PART_SCALE);
      end
      S_COUNT: begin
        if (count_go) begin
          n_r    <= n_r + NW'(1);
          lhs_r  <= lhs_r + step_r;
          step_r <= step_r + WC'(2 * PART_SCALE);
        end else if (n_r == '0) begin
          n_r <= NW'(1);
        end
      end
      S_DEN: begin
        nsq_r     <= {{NW{1'b0}}, n_r} * {{NW{1'b0}}, n_r};
        i_r       <= '0;
        div_sel_r <= DIV_DX;
        for (int k = 0; k < 2; k++) begin
          b_r[k]  <= b_prod[k][WB-1:0];
          vq_r[k] <= WQ'(p_r[k]);
        end
      end
      S_DIV_GO: begin
        // point 0 is the kept point exactly: value p, remainder n^2 of 2n^2
        vr_r[0] <= DEN_W'(nsq_r);
        vr_r[1] <= DEN_W'(nsq_r);
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          case (div_sel_r)
            DIV_DX: begin
              fq_r[0] <= div_q;
              fr_r[0] <= div_r;
            end
            DIV_SX: begin
              sq_r[0] <= div_q;
              sr_r[0] <= div_r;
            end
            DIV_DY: begin
              fq_r[1] <= div_q;
              fr_r[1] <= div_r;
            end
            DIV_SY: begin
              sq_r[1] <= div_q;
              sr_r[1] <= div_r;
            end
            default: begin
              fq_r[0] <= div_q;
              fr_r[0] <= div_r;
            end
          endcase
          div_sel_r <= div_sel_t'(div_sel_r + 2'd1);
        end
      end
      S_PTS: begin
        if (out_free) begin
          i_r <= i_r + NW'(1);
          for (int k = 0; k < 2; k++) begin
            vq_r[k] <= vq_upd[k];
            vr_r[k] <= vr_upd[k];
            fq_r[k] <= fq_upd[k];
            fr_r[k] <= fr_upd[k];
          end
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      if (state_r == S_PTS) begin
        out_x_r    <= vq_r[0][CW-1:0];
        out_y_r    <= vq_r[1][CW-1:0];
        out_ns_r   <= 1'b0;
        out_last_r <= 1'b0;
      end else begin
        out_x_r    <= e_r[0];
        out_y_r    <= e_r[1];
        out_ns_r   <= (op_r == OP_MOVE);
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.point_x     = out_x_r;
  assign out_if.point_y     = out_y_r;
  assign out_if.new_subpath = out_ns_r;
  assign out_if.last_of_run = out_last_r;

endmodule

### hw/rtl/qbf_checker.sv
// port-level checks of the flattener and their bind to the top level
`include "quadratic_bezier_path_flattener_macros.svh"

module qbf_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input qbf_pkg::opcode_t in_opcode,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_new_subpath,
  input logic             out_last_of_run
);

  import qbf_pkg::*;

  // a stalled point stays offered
  `QBF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "output dropped while stalled")

  // any real element leaves the input not ready in the cycle after its transfer
  `QBF_ASSERT_NXT(a_busy_after_in, in_valid && in_ready && in_opcode != OP_RSVD, !in_ready,
    "input taken again right after an element transfer")

  // a move gives exactly one point, which closes its run
  `QBF_ASSERT_IMP(a_move_last, out_valid && out_new_subpath, out_last_of_run,
    "subpath start on a point that is not last of its run")

  // mid-spline points are offered only while the element is still in work
  `QBF_ASSERT_IMP(a_mid_busy, out_valid && !out_last_of_run, !in_ready,
    "ready for input while a spline is unfinished")

endmodule

bind quadratic_bezier_path_flattener qbf_checker u_qbf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .in_opcode       (in_if.opcode),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_new_subpath (out_if.new_subpath),
  .out_last_of_run (out_if.last_of_run)
);

### tb/quadratic_bezier_path_flattener_tb.sv
// self-checking testbench of the quadratic bezier path flattener
module quadratic_bezier_path_flattener_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qbf_pkg::*;

  localparam int     MAX_PARTS   = 63;
  localparam int     COORD_WIDTH = 32;
  localparam longint PARTS_SCALE = 25 * 65536;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     TAIL_CYCLES = 400;
  localparam int     HOLD_CYCLES = 500;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t CMAX = 32'sh7FFF_FFFF;
  localparam coord_t CMIN = 32'sh8000_0000;

  typedef struct packed {
    opcode_t op;
    coord_t  ex;
    coord_t  ey;
    coord_t  cx;
    coord_t  cy;
    logic    wait_drain;
  } path_elem_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   new_sub;
    logic   last;
  } poly_point_t;

  logic clk;
  logic rst_n;

  qbf_in_if  #(.CW(COORD_WIDTH)) in_ch ();
  qbf_out_if #(.CW(COORD_WIDTH)) out_ch ();

  quadratic_bezier_path_flattener #(
    .MAX_PARTS  (MAX_PARTS),
    .COORD_WIDTH(COORD_WIDTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  path_elem_t  path_elems[$];
  poly_point_t due_points[$];

  // kept point of the flattener as predicted, and as tracked by the generator
  longint kept_x = 0;
  longint kept_y = 0;
  longint gen_x  = 0;
  longint gen_y  = 0;

  int  err_count   = 0;
  int  points_seen = 0;
  int  elems_sent  = 0;
  int  cycles      = 0;
  int  send_gap;
  int  recv_gap;
  int  hold_left;
  bit  hold_done   = 1'b0;
  bit  calm        = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // nearest integer, ties toward plus infinity
  function automatic longint round_div(longint num, longint den);
    longint q;
    longint r;
    q = num / den;
    r = num - q * den;
    if (r < 0) begin
      q = q - 1;
      r = r + den;
    end
    if (r >= den - r) q = q + 1;
    return q;
  endfunction

  function automatic longint bezier_coord(longint p0, longint c, longint p2,
                                          longint i, longint n);
    longint j;
    j = n - i;
    return round_div(p2 * i * i + 2 * c * i * j + p0 * j * j, n * n);
  endfunction

  task automatic flatten_element(opcode_t op, coord_t ex_in, coord_t ey_in,
                                 coord_t cx_in, coord_t cy_in);
    longint      ex;
    longint      ey;
    longint      cx;
    longint      cy;
    longint      d;
    longint      n;
    poly_point_t pt;
    ex = ex_in;
    ey = ey_in;
    cx = cx_in;
    cy = cy_in;
    if (op == OP_RSVD) return;
    if (op == OP_SPLINE) begin
      d = abs_l(ex - 2 * cx + kept_x) + abs_l(ey - 2 * cy + kept_y);
      n = 0;
      while (n < MAX_PARTS && PARTS_SCALE * (n + 1) * (n + 1) <= 144 * d) n++;
      if (n < 1) n = 1;
      for (longint i = 0; i < n; i++) begin
        pt.x       = coord_t'(bezier_coord(kept_x, cx, ex, i, n));
        pt.y       = coord_t'(bezier_coord(kept_y, cy, ey, i, n));
        pt.new_sub = 1'b0;
        pt.last    = 1'b0;
        due_points.push_back(pt);
      end
    end
    pt.x       = ex_in;
    pt.y       = ey_in;
    pt.new_sub = (op == OP_MOVE);
    pt.last    = 1'b1;
    due_points.push_back(pt);
    kept_x = ex;
    kept_y = ey;
  endtask

  task automatic add_elem(opcode_t op, coord_t ex, coord_t ey, coord_t cx, coord_t cy,
                          bit wait_drain = 1'b0);
    path_elem_t e;
    e.op         = op;
    e.ex         = ex;
    e.ey         = ey;
    e.cx         = cx;
    e.cy         = cy;
    e.wait_drain = wait_drain;
    path_elems.push_back(e);
    if (op != OP_RSVD) begin
      gen_x = ex;
      gen_y = ey;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.opcode <= OP_MOVE;
      in_ch.end_x  <= '0;
      in_ch.end_y  <= '0;
      in_ch.ctrl_x <= '0;
      in_ch.ctrl_y <= '0;
      send_gap     <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        flatten_element(in_ch.opcode, in_ch.end_x, in_ch.end_y, in_ch.ctrl_x, in_ch.ctrl_y);
        elems_sent++;
        if (elems_sent % 40 == 0) calm = !calm;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          in_ch.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (path_elems.size() > 0 &&
                     (!path_elems[0].wait_drain || due_points.size() == 0)) begin
          path_elem_t e;
          e = path_elems.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.opcode <= e.op;
          in_ch.end_x  <= e.ex;
          in_ch.end_y  <= e.ey;
          in_ch.ctrl_x <= e.cx;
          in_ch.ctrl_y <= e.cy;
          send_gap     <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver flow control, with one long hold-off once 60 points have been seen
  always @(posedge clk) begin : recv_flow
    int g;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= 0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && points_seen >= 60) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else if (recv_gap > 0) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= recv_gap - 1;
    end else if (out_ch.valid && out_ch.ready) begin
      g = pick_gap();
      out_ch.ready <= (g == 0);
      recv_gap     <= (g == 0) ? 0 : g - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // point checker
  always @(posedge clk) begin : point_check
    poly_point_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      points_seen++;
      if (due_points.size() == 0) begin
        $error("point with none due: x %0d y %0d", out_ch.point_x, out_ch.point_y);
        err_count++;
      end else begin
        want = due_points.pop_front();
        if (out_ch.point_x !== want.x) begin
          $error("point_x expected %0d got %0d", want.x, out_ch.point_x);
          err_count++;
        end
        if (out_ch.point_y !== want.y) begin
          $error("point_y expected %0d got %0d", want.y, out_ch.point_y);
          err_count++;
        end
        if (out_ch.new_subpath !== want.new_sub) begin
          $error("new_subpath expected %0b got %0b", want.new_sub, out_ch.new_subpath);
          err_count++;
        end
        if (out_ch.last_of_run !== want.last) begin
          $error("last_of_run expected %0b got %0b", want.last, out_ch.last_of_run);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int     made;
    int     r;
    int     lim;
    int     off;
    longint mx;
    longint my;
    coord_t ex;
    coord_t ey;

    rst_n = 1'b0;

    // spline from the reset point, then part count exactly on and just below 3
    add_elem(OP_SPLINE, 32'sh0002_0000, 32'sh0, 32'sh0001_0000, 32'sh0002_0000);
    add_elem(OP_MOVE, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
    add_elem(OP_SPLINE, 32'sd102400, 32'sh0, 32'sh0, 32'sh0);
    add_elem(OP_MOVE, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
    add_elem(OP_SPLINE, 32'sd102399, 32'sh0, 32'sh0, 32'sh0);
    // straight spline: zero second difference, one part
    add_elem(OP_SPLINE, 32'sd233471, 32'sh0, 32'sd167935, 32'sh0);
    add_elem(OP_RSVD, coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), coord_t'($urandom));
    add_elem(OP_MOVE, CMAX, CMIN, CMIN, CMAX);
    add_elem(OP_LINE, CMIN, CMAX, CMAX, CMIN);
    add_elem(OP_SPLINE, CMAX, CMAX, CMIN, CMIN);
    add_elem(OP_SPLINE, CMIN, CMIN, CMAX, CMAX);
    add_elem(OP_LINE, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
    add_elem(OP_SPLINE, -32'sd3, -32'sd5, -32'sh0005_0000, 32'sh0007_0000);
    add_elem(OP_MOVE, 32'sh1234_5678, -32'sh1234_5678, coord_t'($urandom),
             coord_t'($urandom));
    add_elem(OP_LINE, 32'sh0, 32'sh0, 32'sh0, 32'sh0);
    add_elem(OP_RSVD, CMAX, CMIN, CMAX, CMIN);
    add_elem(OP_SPLINE, 32'sd1, 32'sd1, 32'sd0, 32'sd1);
    add_elem(OP_SPLINE, 32'sh0010_0000, -32'sh0010_0000, 32'sh0040_0000, 32'sh0040_0000);

    made = 0;
    while (made < 150) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        add_elem(OP_RSVD, coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom));
        continue;
      end
      if (r < 20) begin
        add_elem(OP_MOVE, coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom), made == 0 || made == 75);
      end else if (r < 40) begin
        add_elem(OP_LINE, coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom), made == 0 || made == 75);
      end else if (r < 85) begin
        // control point near the chord midpoint keeps the part count modest
        ex = coord_t'(int'($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000);
        ey = coord_t'(int'($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000);
        case ($urandom_range(0, 3))
          0:       lim = 32'h100;
          1:       lim = 32'h8000;
          2:       lim = 32'h4_0000;
          default: lim = 32'h20_0000;
        endcase
        mx  = (gen_x + longint'(ex)) >>> 1;
        my  = (gen_y + longint'(ey)) >>> 1;
        off = $urandom_range(0, lim);
        mx  = (mx >= 0) ? mx - off : mx + off;
        off = $urandom_range(0, lim);
        my  = (my >= 0) ? my - off : my + off;
        add_elem(OP_SPLINE, ex, ey, coord_t'(mx), coord_t'(my), made == 0 || made == 75);
      end else begin
        add_elem(OP_SPLINE, coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), coord_t'($urandom), made == 0 || made == 75);
      end
      made++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (path_elems.size() > 0 || in_ch.valid || due_points.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
